[rtl/ihb_pkg.sv]
// ----------------------------------------------------------------------------
// ihb_pkg
// Shared types and constants for the IPv4 TCP/UDP header builder.
// ----------------------------------------------------------------------------
package ihb_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPED_SRC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPED_DST   = 2'd2;

    // commands
    localparam logic [1:0] CMD_DESC    = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_CLOSE   = 2'd2;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [5:0] HLEN_IP  = 6'd20;
    localparam logic [5:0] HLEN_UDP = 6'd28;
    localparam logic [5:0] HLEN_TCP = 6'd40;

    localparam logic [15:0] IP_ID       = 16'd12345;
    localparam logic [7:0]  IP_TTL      = 8'd64;
    localparam logic [15:0] IP_VER_IHL  = 16'h4500;
    localparam logic [15:0] TCP_SEQ_ACK = 16'd1000;
    localparam logic [15:0] TCP_OFF_FLG = 16'h5018;
    localparam logic [15:0] TCP_WINDOW  = 16'd8192;

    // fixed words of the ip header and the tcp header, summed once
    localparam logic [17:0] IP_CONST_SUM  = 18'(IP_VER_IHL) + 18'(IP_ID) + 18'({IP_TTL, 8'h00});
    localparam logic [17:0] TCP_CONST_SUM = 18'(TCP_SEQ_ACK) + 18'(TCP_SEQ_ACK)
                                          + 18'(TCP_OFF_FLG) + 18'(TCP_WINDOW);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef enum logic {
        JOB_PAYLOAD = 1'b0,
        JOB_HEADER  = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;
        logic [15:0] offset;
        logic        too_long;
        logic [7:0]  protocol;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] psum;
        logic [15:0] odd_word;
        logic [15:0] total;
        logic [15:0] tlen;
    } job_t;

    function automatic logic [5:0] hdr_len(input logic [7:0] proto);
        logic [5:0] len;
        if (proto == PROTO_TCP)
        begin
            len = HLEN_TCP;
        end
        else if (proto == PROTO_UDP)
        begin
            len = HLEN_UDP;
        end
        else
        begin
            len = HLEN_IP;
        end
        return len;
    endfunction

endpackage

[rtl/ipv4_tcp_udp_header_builder.sv]
// path: a payload byte goes through the job queue slot and then the output register.
// throughput: one payload byte per cycle while out_ready is high and no header is in
// progress; a close holds the back part for the queue pop and checksum steps, then
// one header byte per cycle while out_ready is high (20, 28 or 40 bytes)
// reset: asynchronous, active low; clears all packet state and config registers
// ----------------------------------------------------------------------------
// ipv4_tcp_udp_header_builder
// Streams payload bytes with packet offsets and emits IPv4/TCP/UDP headers.
// ----------------------------------------------------------------------------
module ipv4_tcp_udp_header_builder #(
    parameter int MAX_PAYLOAD = 1460
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ihb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ihb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [7:0]                     protocol,
    input  logic [31:0]                    source_ip,
    input  logic [31:0]                    destination_ip,
    input  logic [15:0]                    source_port,
    input  logic [15:0]                    destination_port,
    input  logic                           server_to_client,
    input  logic [7:0]                     payload_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic [15:0]                    byte_offset,
    output logic                           is_header,
    output logic                           last,
    output logic                           too_long
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    ihb_pkg::job_t push_job;
    ihb_pkg::job_t head_job;

    ihb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .protocol         (protocol),
        .source_ip        (source_ip),
        .destination_ip   (destination_ip),
        .source_port      (source_port),
        .destination_port (destination_port),
        .server_to_client (server_to_client),
        .payload_byte     (payload_byte),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_job            (push_job)
    );

    ihb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    ihb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_offset (byte_offset),
        .is_header   (is_header),
        .last        (last),
        .too_long    (too_long)
    );

endmodule

[rtl/ihb_front.sv]
// ----------------------------------------------------------------------------
// ihb_front
// Accepts items, keeps packet state and the payload sum, queues output jobs.
// ----------------------------------------------------------------------------
module ihb_front #(
    parameter int MAX_PAYLOAD = 1460
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ihb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ihb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [7:0]                     protocol,
    input  logic [31:0]                    source_ip,
    input  logic [31:0]                    destination_ip,
    input  logic [15:0]                    source_port,
    input  logic [15:0]                    destination_port,
    input  logic                           server_to_client,
    input  logic [7:0]                     payload_byte,
    input  logic                           q_full,
    output logic                           q_push,
    output ihb_pkg::job_t                  q_job
);

    localparam logic [15:0] MaxCount = 16'(MAX_PAYLOAD);

    logic        remap_reg;
    logic [31:0] map_src_reg;
    logic [31:0] map_dst_reg;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [15:0] sport_reg;
    logic [15:0] dport_reg;
    logic [15:0] psum_reg;
    logic [15:0] count_reg;
    logic        odd_valid_reg;
    logic [7:0]  odd_byte_reg;
    logic        ovf_reg;

    logic        accept;
    logic        room;
    logic [5:0]  hlen;
    logic [15:0] offset;
    logic [16:0] sum_raw;
    logic [15:0] psum_next;
    logic [31:0] src_sel;
    logic [31:0] dst_sel;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign room     = count_reg < MaxCount;
    assign hlen     = ihb_pkg::hdr_len(proto_reg);
    assign offset   = count_reg + {10'd0, hlen};

    // end-around carry add of the completed payload word
    assign sum_raw   = {1'b0, psum_reg} + {1'b0, odd_byte_reg, payload_byte};
    assign psum_next = sum_raw[15:0] + {15'd0, sum_raw[16]};

    always_comb
    begin
        src_sel = source_ip;
        dst_sel = destination_ip;
        if (remap_reg)
        begin
            if (server_to_client)
            begin
                src_sel = map_src_reg;
                dst_sel = map_dst_reg;
            end
            else
            begin
                src_sel = map_dst_reg;
                dst_sel = map_src_reg;
            end
        end
    end

    always_comb
    begin
        q_job.kind     = (command == ihb_pkg::CMD_CLOSE) ? ihb_pkg::JOB_HEADER
                                                         : ihb_pkg::JOB_PAYLOAD;
        q_job.data     = payload_byte;
        q_job.offset   = offset;
        q_job.too_long = ovf_reg;
        q_job.protocol = proto_reg;
        q_job.src      = src_reg;
        q_job.dst      = dst_reg;
        q_job.sport    = sport_reg;
        q_job.dport    = dport_reg;
        q_job.psum     = psum_reg;
        q_job.odd_word = odd_valid_reg ? {odd_byte_reg, 8'h00} : 16'h0000;
        q_job.total    = offset;
        q_job.tlen     = count_reg + {10'd0, hlen - ihb_pkg::HLEN_IP};
    end

    assign q_push = accept && (((command == ihb_pkg::CMD_PAYLOAD) && room)
                               || (command == ihb_pkg::CMD_CLOSE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remap_reg   <= 1'b0;
            map_src_reg <= 32'd0;
            map_dst_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ihb_pkg::CFG_REMAP_ENABLE: remap_reg   <= cfg_data[0];
                ihb_pkg::CFG_MAPPED_SRC:   map_src_reg <= cfg_data;
                ihb_pkg::CFG_MAPPED_DST:   map_dst_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_reg     <= 8'd0;
            src_reg       <= 32'd0;
            dst_reg       <= 32'd0;
            sport_reg     <= 16'd0;
            dport_reg     <= 16'd0;
            psum_reg      <= 16'd0;
            count_reg     <= 16'd0;
            odd_valid_reg <= 1'b0;
            odd_byte_reg  <= 8'd0;
            ovf_reg       <= 1'b0;
        end
        else if (accept)
        begin
            if (command == ihb_pkg::CMD_DESC)
            begin
                proto_reg     <= protocol;
                src_reg       <= src_sel;
                dst_reg       <= dst_sel;
                sport_reg     <= source_port;
                dport_reg     <= destination_port;
                psum_reg      <= 16'd0;
                count_reg     <= 16'd0;
                odd_valid_reg <= 1'b0;
                odd_byte_reg  <= 8'd0;
                ovf_reg       <= 1'b0;
            end
            else if (command == ihb_pkg::CMD_PAYLOAD)
            begin
                if (!room)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    if (odd_valid_reg)
                    begin
                        psum_reg      <= psum_next;
                        odd_valid_reg <= 1'b0;
                        odd_byte_reg  <= 8'd0;
                    end
                    else
                    begin
                        odd_valid_reg <= 1'b1;
                        odd_byte_reg  <= payload_byte;
                    end
                    count_reg <= count_reg + 16'd1;
                end
            end
        end
    end

endmodule

[rtl/ihb_queue.sv]
// ----------------------------------------------------------------------------
// ihb_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module ihb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ihb_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output ihb_pkg::job_t head_job,
    output logic          empty
);

    ihb_pkg::job_t               slot_reg [ihb_pkg::QDEPTH];
    logic [ihb_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [ihb_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [ihb_pkg::QPTR_W:0]    count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full     = count_reg == (ihb_pkg::QPTR_W + 1)'(ihb_pkg::QDEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/ihb_back.sv]
// ----------------------------------------------------------------------------
// ihb_back
// Drains jobs: forwards payload bytes, sums checksums and emits headers.
// ----------------------------------------------------------------------------
module ihb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  ihb_pkg::job_t head_job,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [15:0]   byte_offset,
    output logic          is_header,
    output logic          last,
    output logic          too_long
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_SUM  = 3'b010,
        B_EMIT = 3'b100
    } back_state_t;

    localparam logic [2:0] STEP_LAST = 3'd4;

    back_state_t   state_reg;
    logic [2:0]    step_reg;
    logic [5:0]    idx_reg;
    ihb_pkg::job_t job_reg;
    logic [20:0]   ip_acc_reg;
    logic [20:0]   tp_acc_reg;
    logic [15:0]   ip_ck_reg;
    logic [15:0]   tp_ck_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic [15:0]   offset_reg;
    logic          hdr_reg;
    logic          last_reg;
    logic          too_long_reg;

    logic          can_load;
    logic          out_load;
    logic          is_tcp;
    logic          is_udp;
    logic [5:0]    hlen;
    logic          hdr_last;
    logic [17:0]   ip_add;
    logic [17:0]   tp_add;
    logic [15:0]   tp_ck_raw;
    logic [7:0]    hdr_byte;

    function automatic logic [15:0] fold(input logic [20:0] acc);
        logic [16:0] f1;
        logic [15:0] f2;
        f1 = {1'b0, acc[15:0]} + {12'd0, acc[20:16]};
        f2 = f1[15:0] + {15'd0, f1[16]};
        return f2;
    endfunction

    assign can_load = !out_valid_reg || out_ready;
    assign is_tcp   = job_reg.protocol == ihb_pkg::PROTO_TCP;
    assign is_udp   = job_reg.protocol == ihb_pkg::PROTO_UDP;
    assign hlen     = ihb_pkg::hdr_len(job_reg.protocol);
    assign hdr_last = idx_reg == (hlen - 6'd1);

    assign q_pop = (state_reg == B_IDLE) && !q_empty
                   && ((head_job.kind == ihb_pkg::JOB_HEADER) || can_load);

    // a new item goes into the output register
    assign out_load = (q_pop && (head_job.kind == ihb_pkg::JOB_PAYLOAD))
                      || ((state_reg == B_EMIT) && can_load);

    // a few words of each checksum per step
    always_comb
    begin
        ip_add = 18'd0;
        tp_add = 18'd0;
        unique case (step_reg)
            3'd0:
            begin
                ip_add = 18'(job_reg.total) + 18'(job_reg.protocol) + ihb_pkg::IP_CONST_SUM;
                tp_add = 18'(job_reg.psum) + 18'(job_reg.odd_word) + 18'(job_reg.sport);
            end
            3'd1:
            begin
                ip_add = 18'(job_reg.src[31:16]) + 18'(job_reg.src[15:0]);
                tp_add = 18'(job_reg.src[31:16]) + 18'(job_reg.src[15:0])
                       + 18'(job_reg.dport);
            end
            3'd2:
            begin
                ip_add = 18'(job_reg.dst[31:16]) + 18'(job_reg.dst[15:0]);
                tp_add = 18'(job_reg.dst[31:16]) + 18'(job_reg.dst[15:0])
                       + 18'(job_reg.protocol);
            end
            3'd3:
            begin
                // pseudo-header length, udp length field, fixed tcp words
                tp_add = 18'(job_reg.tlen) + (is_udp ? 18'(job_reg.tlen) : 18'd0)
                       + (is_tcp ? ihb_pkg::TCP_CONST_SUM : 18'd0);
            end
            default:
            begin
                ip_add = 18'd0;
                tp_add = 18'd0;
            end
        endcase
    end

    assign tp_ck_raw = ~fold(tp_acc_reg);

    always_comb
    begin
        case (idx_reg)
            6'd0:  hdr_byte = ihb_pkg::IP_VER_IHL[15:8];
            6'd1:  hdr_byte = ihb_pkg::IP_VER_IHL[7:0];
            6'd2:  hdr_byte = job_reg.total[15:8];
            6'd3:  hdr_byte = job_reg.total[7:0];
            6'd4:  hdr_byte = ihb_pkg::IP_ID[15:8];
            6'd5:  hdr_byte = ihb_pkg::IP_ID[7:0];
            6'd8:  hdr_byte = ihb_pkg::IP_TTL;
            6'd9:  hdr_byte = job_reg.protocol;
            6'd10: hdr_byte = ip_ck_reg[15:8];
            6'd11: hdr_byte = ip_ck_reg[7:0];
            6'd12: hdr_byte = job_reg.src[31:24];
            6'd13: hdr_byte = job_reg.src[23:16];
            6'd14: hdr_byte = job_reg.src[15:8];
            6'd15: hdr_byte = job_reg.src[7:0];
            6'd16: hdr_byte = job_reg.dst[31:24];
            6'd17: hdr_byte = job_reg.dst[23:16];
            6'd18: hdr_byte = job_reg.dst[15:8];
            6'd19: hdr_byte = job_reg.dst[7:0];
            6'd20: hdr_byte = job_reg.sport[15:8];
            6'd21: hdr_byte = job_reg.sport[7:0];
            6'd22: hdr_byte = job_reg.dport[15:8];
            6'd23: hdr_byte = job_reg.dport[7:0];
            6'd24: hdr_byte = is_tcp ? 8'h00 : job_reg.tlen[15:8];
            6'd25: hdr_byte = is_tcp ? 8'h00 : job_reg.tlen[7:0];
            6'd26: hdr_byte = is_tcp ? ihb_pkg::TCP_SEQ_ACK[15:8] : tp_ck_reg[15:8];
            6'd27: hdr_byte = is_tcp ? ihb_pkg::TCP_SEQ_ACK[7:0] : tp_ck_reg[7:0];
            6'd30: hdr_byte = ihb_pkg::TCP_SEQ_ACK[15:8];
            6'd31: hdr_byte = ihb_pkg::TCP_SEQ_ACK[7:0];
            6'd32: hdr_byte = ihb_pkg::TCP_OFF_FLG[15:8];
            6'd33: hdr_byte = ihb_pkg::TCP_OFF_FLG[7:0];
            6'd34: hdr_byte = ihb_pkg::TCP_WINDOW[15:8];
            6'd35: hdr_byte = ihb_pkg::TCP_WINDOW[7:0];
            6'd36: hdr_byte = tp_ck_reg[15:8];
            6'd37: hdr_byte = tp_ck_reg[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (head_job.kind == ihb_pkg::JOB_HEADER))
        begin
            job_reg <= head_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= 3'd0;
            idx_reg       <= 6'd0;
            ip_acc_reg    <= 21'd0;
            tp_acc_reg    <= 21'd0;
            ip_ck_reg     <= 16'd0;
            tp_ck_reg     <= 16'd0;
            out_byte_reg  <= 8'd0;
            offset_reg    <= 16'd0;
            hdr_reg       <= 1'b0;
            last_reg      <= 1'b0;
            too_long_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (head_job.kind == ihb_pkg::JOB_HEADER)
                        begin
                            state_reg  <= B_SUM;
                            step_reg   <= 3'd0;
                            ip_acc_reg <= 21'd0;
                            tp_acc_reg <= 21'd0;
                        end
                        else
                        begin
                            out_byte_reg  <= head_job.data;
                            offset_reg    <= head_job.offset;
                            hdr_reg       <= 1'b0;
                            last_reg      <= 1'b0;
                            too_long_reg  <= head_job.too_long;
                        end
                    end
                end
                B_SUM:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        ip_ck_reg <= ~fold(ip_acc_reg);
                        // udp sends a zero checksum as all ones
                        tp_ck_reg <= (is_udp && (tp_ck_raw == 16'h0000)) ? 16'hFFFF
                                                                          : tp_ck_raw;
                        idx_reg   <= 6'd0;
                        state_reg <= B_EMIT;
                    end
                    else
                    begin
                        ip_acc_reg <= ip_acc_reg + 21'(ip_add);
                        tp_acc_reg <= tp_acc_reg + 21'(tp_add);
                        step_reg   <= step_reg + 3'd1;
                    end
                end
                B_EMIT:
                begin
                    if (can_load)
                    begin
                        out_byte_reg  <= hdr_byte;
                        offset_reg    <= {10'd0, idx_reg};
                        hdr_reg       <= 1'b1;
                        last_reg      <= hdr_last;
                        too_long_reg  <= job_reg.too_long;
                        idx_reg       <= idx_reg + 6'd1;
                        if (hdr_last)
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_offset = offset_reg;
    assign is_header   = hdr_reg;
    assign last        = last_reg;
    assign too_long    = too_long_reg;

endmodule

[rtl/ihb_checker.sv]
// ----------------------------------------------------------------------------
// ihb_checker
// Port-level checks on the output stream of the header builder.
// ----------------------------------------------------------------------------
module ihb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic [15:0] byte_offset,
    input logic        is_header,
    input logic        last
);

    // a stalled item stays on the port
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> is_header)
        else $error("last flag on a payload item");

    // header bytes follow each other without gaps, offsets counting up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_header && !last
        |=> out_valid && is_header && (byte_offset == $past(byte_offset) + 16'd1))
        else $error("header run broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_header && (byte_offset == 16'd0) |-> out_byte == 8'h45)
        else $error("header does not start with version and length");

endmodule

bind ipv4_tcp_udp_header_builder ihb_checker u_ihb_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the IPv4 TCP/UDP header builder. Descriptors, payload bytes
// and closes go in under random flow control on both sides. A built-in model
// of the packet, its header and both checksums predicts every output byte,
// which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int PAYLOAD_LIMIT  = 1460;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 80;
    localparam int MAX_REPORTS    = 40;

    localparam logic [1:0]                    CMD_UNUSED = 2'd3;
    localparam logic [ihb_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    localparam logic [7:0]  PKT_VER_IHL = 8'h45;
    localparam logic [15:0] PKT_IDENT   = 16'd12345;
    localparam logic [7:0]  PKT_TTL     = 8'd64;
    localparam logic [15:0] SEQ_ACK_NUM = 16'd1000;
    localparam logic [7:0]  TCP_DOFF    = 8'h50;
    localparam logic [7:0]  TCP_FLAGS   = 8'h18;  // psh + ack
    localparam logic [15:0] WINDOW_SIZE = 16'd8192;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        s2c;
        logic [7:0]  data;
    } packet_item_t;

    typedef struct {
        logic [7:0]  data;
        logic [15:0] offset;
        logic        hdr;
        logic        is_last;
        logic        ovf;
    } packet_byte_t;

    logic                           clk              = 1'b0;
    logic                           rst_n            = 1'b0;
    logic                           cfg_write        = 1'b0;
    logic [ihb_pkg::CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [ihb_pkg::CFG_DATA_W-1:0] cfg_data         = '0;
    logic                           in_valid         = 1'b0;
    logic                           in_ready;
    logic [1:0]                     command          = '0;
    logic [7:0]                     protocol         = '0;
    logic [31:0]                    source_ip        = '0;
    logic [31:0]                    destination_ip   = '0;
    logic [15:0]                    source_port      = '0;
    logic [15:0]                    destination_port = '0;
    logic                           server_to_client = 1'b0;
    logic [7:0]                     payload_byte     = '0;
    logic                           out_valid;
    logic                           out_ready        = 1'b0;
    logic [7:0]                     out_byte;
    logic [15:0]                    byte_offset;
    logic                           is_header;
    logic                           last;
    logic                           too_long;

    // packet state as the block should hold it
    logic        remap_on   = 1'b0;
    logic [31:0] server_ip  = '0;
    logic [31:0] client_ip  = '0;
    logic [7:0]  held_proto = '0;
    logic [31:0] held_src   = '0;
    logic [31:0] held_dst   = '0;
    logic [15:0] held_sport = '0;
    logic [15:0] held_dport = '0;
    logic [15:0] pay_sum    = '0;
    logic [15:0] pay_count  = '0;
    logic        odd_valid  = 1'b0;
    logic [7:0]  odd_byte   = '0;
    logic        overflow   = 1'b0;

    packet_byte_t pending_bytes[$];
    packet_byte_t oldest;

    int mismatch_count = 0;
    int items_sent     = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;

    ipv4_tcp_udp_header_builder #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .protocol         (protocol),
        .source_ip        (source_ip),
        .destination_ip   (destination_ip),
        .source_port      (source_port),
        .destination_port (destination_port),
        .server_to_client (server_to_client),
        .payload_byte     (payload_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte         (out_byte),
        .byte_offset      (byte_offset),
        .is_header        (is_header),
        .last             (last),
        .too_long         (too_long)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [15:0] stack_len(input logic [7:0] proto);
        if (proto == ihb_pkg::PROTO_TCP)
        begin
            return 16'd40;
        end
        if (proto == ihb_pkg::PROTO_UDP)
        begin
            return 16'd28;
        end
        return 16'd20;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 32'h0000_0000;
        end
        if (r == 1)
        begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    function automatic logic [15:0] random_port();
        return 16'($urandom_range(0, 65535));
    endfunction

    // unused fields carry random values too
    function automatic packet_item_t random_item(input logic [1:0] cmd);
        packet_item_t it;
        it.cmd   = cmd;
        it.proto = 8'($urandom_range(0, 255));
        it.sip   = $urandom;
        it.dip   = $urandom;
        it.sport = random_port();
        it.dport = random_port();
        it.s2c   = 1'($urandom_range(0, 1));
        it.data  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("%0t mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    task automatic build_expected_bytes(input packet_item_t it);
        logic [7:0]   hb [0:39];
        logic [15:0]  hlen;
        logic [15:0]  total;
        logic [15:0]  tlen;
        logic [15:0]  s;
        logic [15:0]  ck;
        packet_byte_t nb;
        hlen = stack_len(held_proto);
        case (it.cmd)
            ihb_pkg::CMD_DESC:
            begin
                held_src = it.sip;
                held_dst = it.dip;
                if (remap_on)
                begin
                    held_src = it.s2c ? server_ip : client_ip;
                    held_dst = it.s2c ? client_ip : server_ip;
                end
                held_proto = it.proto;
                held_sport = it.sport;
                held_dport = it.dport;
                pay_sum    = '0;
                pay_count  = '0;
                odd_valid  = 1'b0;
                odd_byte   = '0;
                overflow   = 1'b0;
            end
            ihb_pkg::CMD_PAYLOAD:
            begin
                if (pay_count >= PAYLOAD_LIMIT)
                begin
                    overflow = 1'b1;
                end
                else
                begin
                    if (odd_valid)
                    begin
                        pay_sum   = ones_add(pay_sum, {odd_byte, it.data});
                        odd_valid = 1'b0;
                    end
                    else
                    begin
                        odd_valid = 1'b1;
                        odd_byte  = it.data;
                    end
                    nb.data    = it.data;
                    nb.offset  = hlen + pay_count;
                    nb.hdr     = 1'b0;
                    nb.is_last = 1'b0;
                    nb.ovf     = overflow;
                    pending_bytes.push_back(nb);
                    pay_count++;
                end
            end
            ihb_pkg::CMD_CLOSE:
            begin
                for (int i = 0; i < 40; i++)
                begin
                    hb[i] = 8'h00;
                end
                total = hlen + pay_count;
                hb[0] = PKT_VER_IHL;
                hb[2] = total[15:8];
                hb[3] = total[7:0];
                hb[4] = PKT_IDENT[15:8];
                hb[5] = PKT_IDENT[7:0];
                hb[8] = PKT_TTL;
                hb[9] = held_proto;
                for (int k = 0; k < 4; k++)
                begin
                    hb[12 + k] = held_src[31 - 8 * k -: 8];
                    hb[16 + k] = held_dst[31 - 8 * k -: 8];
                end
                s = '0;
                for (int i = 0; i < 20; i += 2)
                begin
                    s = ones_add(s, {hb[i], hb[i + 1]});
                end
                ck     = ~s;
                hb[10] = ck[15:8];
                hb[11] = ck[7:0];
                if (hlen > 16'd20)
                begin
                    tlen   = hlen - 16'd20 + pay_count;
                    hb[20] = held_sport[15:8];
                    hb[21] = held_sport[7:0];
                    hb[22] = held_dport[15:8];
                    hb[23] = held_dport[7:0];
                    if (hlen == 16'd40)
                    begin
                        hb[26] = SEQ_ACK_NUM[15:8];
                        hb[27] = SEQ_ACK_NUM[7:0];
                        hb[30] = SEQ_ACK_NUM[15:8];
                        hb[31] = SEQ_ACK_NUM[7:0];
                        hb[32] = TCP_DOFF;
                        hb[33] = TCP_FLAGS;
                        hb[34] = WINDOW_SIZE[15:8];
                        hb[35] = WINDOW_SIZE[7:0];
                    end
                    else
                    begin
                        hb[24] = tlen[15:8];
                        hb[25] = tlen[7:0];
                    end
                    // a trailing odd byte counts as the high half of a padded word
                    s = pay_sum;
                    if (odd_valid)
                    begin
                        s = ones_add(s, {odd_byte, 8'h00});
                    end
                    s = ones_add(s, held_src[31:16]);
                    s = ones_add(s, held_src[15:0]);
                    s = ones_add(s, held_dst[31:16]);
                    s = ones_add(s, held_dst[15:0]);
                    s = ones_add(s, {8'h00, held_proto});
                    s = ones_add(s, tlen);
                    for (int i = 20; i < hlen; i += 2)
                    begin
                        s = ones_add(s, {hb[i], hb[i + 1]});
                    end
                    ck = ~s;
                    if (hlen == 16'd40)
                    begin
                        hb[36] = ck[15:8];
                        hb[37] = ck[7:0];
                    end
                    else
                    begin
                        // udp sends a zero checksum as all ones
                        if (ck == 16'h0000)
                        begin
                            ck = 16'hFFFF;
                        end
                        hb[26] = ck[15:8];
                        hb[27] = ck[7:0];
                    end
                end
                for (int i = 0; i < hlen; i++)
                begin
                    nb.data    = hb[i];
                    nb.offset  = 16'(i);
                    nb.hdr     = 1'b1;
                    nb.is_last = (i + 1 == hlen);
                    nb.ovf     = overflow;
                    pending_bytes.push_back(nb);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // call only at a clock edge where in_valid has not been assigned yet
    task automatic send_item(input packet_item_t it);
        int gap;
        gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        command          <= it.cmd;
        protocol         <= it.proto;
        source_ip        <= it.sip;
        destination_ip   <= it.dip;
        source_port      <= it.sport;
        destination_port <= it.dport;
        server_to_client <= it.s2c;
        payload_byte     <= it.data;
        do
            @(posedge clk);
        while (!in_ready);
        build_expected_bytes(it);
        if (it.cmd != CMD_UNUSED)
        begin
            items_sent++;
        end
    endtask

    task automatic send_desc(input logic [7:0] proto, input logic [31:0] sip,
                             input logic [31:0] dip, input logic [15:0] sport,
                             input logic [15:0] dport, input logic s2c);
        packet_item_t it;
        it       = random_item(ihb_pkg::CMD_DESC);
        it.proto = proto;
        it.sip   = sip;
        it.dip   = dip;
        it.sport = sport;
        it.dport = dport;
        it.s2c   = s2c;
        send_item(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        packet_item_t it;
        it      = random_item(ihb_pkg::CMD_PAYLOAD);
        it.data = b;
        send_item(it);
    endtask

    task automatic send_random_bytes(input int n);
        repeat (n) send_item(random_item(ihb_pkg::CMD_PAYLOAD));
    endtask

    task automatic send_close();
        send_item(random_item(ihb_pkg::CMD_CLOSE));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // block must be idle
    task automatic set_register(input logic [ihb_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            ihb_pkg::CFG_REMAP_ENABLE: remap_on  = value[0];
            ihb_pkg::CFG_MAPPED_SRC:   server_ip = value;
            ihb_pkg::CFG_MAPPED_DST:   client_ip = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic reconfigure(input logic remap, input logic [31:0] srv,
                               input logic [31:0] cli);
        wait_for_results();
        set_register(ihb_pkg::CFG_REMAP_ENABLE, {31'd0, remap});
        set_register(ihb_pkg::CFG_MAPPED_SRC, srv);
        set_register(ihb_pkg::CFG_MAPPED_DST, cli);
    endtask

    // reset state stands in for a descriptor
    task automatic test_before_descriptor();
        send_byte(8'hA5);
        send_byte(8'h3C);
        send_byte(8'h00);
        send_close();
        send_item(random_item(CMD_UNUSED));
    endtask

    task automatic test_field_extremes();
        send_desc(ihb_pkg::PROTO_TCP, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'h0000,
                  1'b1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_close();
        send_desc(ihb_pkg::PROTO_UDP, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF,
                  1'b0);
        send_close();
        send_desc(8'hFF, $urandom, $urandom, random_port(), random_port(), 1'b1);
        send_byte(8'h80);
        send_close();
        send_desc(8'h00, $urandom, $urandom, 16'h0000, 16'h0000, 1'b0);
        send_close();
    endtask

    // all-zero addresses and ports, payload word chosen so the sum is all ones
    task automatic test_udp_zero_checksum();
        send_desc(ihb_pkg::PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0);
        send_byte(8'hFF);
        send_byte(8'hDA);
        send_close();
    endtask

    task automatic test_close_repeat();
        send_desc(ihb_pkg::PROTO_TCP, $urandom, $urandom, random_port(), random_port(),
                  1'b0);
        send_random_bytes(3);
        send_close();
        send_close();
        send_random_bytes(2);
        send_item(random_item(CMD_UNUSED));
        send_close();
        // a new descriptor mid-packet starts over
        send_desc(ihb_pkg::PROTO_UDP, $urandom, $urandom, 16'h1234, 16'h5678, 1'b1);
        send_random_bytes(5);
        send_desc(ihb_pkg::PROTO_UDP, $urandom, $urandom, 16'h4321, 16'h8765, 1'b0);
        send_byte(8'h5A);
        send_close();
    endtask

    task automatic test_remap();
        reconfigure(1'b1, $urandom, $urandom);
        send_desc(ihb_pkg::PROTO_TCP, $urandom, $urandom, 16'd80, 16'd40000, 1'b1);
        send_byte(8'h11);
        send_close();
        send_desc(ihb_pkg::PROTO_UDP, $urandom, $urandom, 16'd53, 16'd5353, 1'b0);
        send_random_bytes(3);
        send_close();
        reconfigure(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        send_desc(ihb_pkg::PROTO_TCP, $urandom, $urandom, 16'd443, 16'd1025, 1'b1);
        send_close();
        send_desc(ihb_pkg::PROTO_TCP, $urandom, $urandom, 16'd443, 16'd1025, 1'b0);
        send_close();
        wait_for_results();
        set_register(CFG_SPARE, $urandom);
        reconfigure(1'b0, $urandom, $urandom);
        send_desc(ihb_pkg::PROTO_UDP, $urandom, $urandom, 16'd7, 16'd9, 1'b1);
        send_close();
    endtask

    task automatic test_payload_limit();
        send_desc(ihb_pkg::PROTO_UDP, $urandom, $urandom, random_port(), random_port(),
                  1'b0);
        send_random_bytes(PAYLOAD_LIMIT);
        send_close();
        // these are dropped and raise too_long
        send_random_bytes(3);
        send_close();
        send_desc(ihb_pkg::PROTO_TCP, $urandom, $urandom, 16'd1, 16'd2, 1'b1);
        send_byte(8'h42);
        send_close();
    endtask

    task automatic send_random_packet();
        packet_item_t it;
        int           r;
        int           nbytes;
        if ($urandom_range(0, 99) < 8)
        begin
            // stray item, any command
            send_item(random_item(2'($urandom_range(0, 3))));
            return;
        end
        it = random_item(ihb_pkg::CMD_DESC);
        r  = $urandom_range(0, 99);
        if (r < 40)
        begin
            it.proto = ihb_pkg::PROTO_TCP;
        end
        else if (r < 75)
        begin
            it.proto = ihb_pkg::PROTO_UDP;
        end
        it.sip = random_addr();
        it.dip = random_addr();
        nbytes = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 120);
        send_item(it);
        send_random_bytes(nbytes);
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            // left open, the next descriptor abandons it
            return;
        end
        send_close();
        if (r < 20)
        begin
            send_close();
        end
        else if (r < 30)
        begin
            send_random_bytes($urandom_range(1, 3));
            send_close();
        end
    endtask

    task automatic test_random_traffic();
        int goal;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: reconfigure(1'b0, $urandom, $urandom);
                1: reconfigure(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
                2: reconfigure(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
                4: reconfigure(1'b0, 32'h0000_0000, 32'h0000_0000);
                default: reconfigure(1'b1, $urandom, $urandom);
            endcase
            send_gap_pct   = (phase == 0) ? 0 : 10 + 25 * $urandom_range(0, 2);
            recv_stall_pct = (phase == 0) ? 0 : 10 + 25 * $urandom_range(0, 2);
            goal           = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                send_random_packet();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < recv_stall_pct)
        begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap() - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h at offset %0d",
                                          out_byte, byte_offset));
            end
            else
            begin
                oldest = pending_bytes.pop_front();
                if (out_byte !== oldest.data)
                begin
                    report_mismatch($sformatf("out_byte at offset %0d: got %02h, want %02h",
                                              oldest.offset, out_byte, oldest.data));
                end
                if (byte_offset !== oldest.offset)
                begin
                    report_mismatch($sformatf("byte_offset: got %0d, want %0d",
                                              byte_offset, oldest.offset));
                end
                if (is_header !== oldest.hdr)
                begin
                    report_mismatch($sformatf("is_header at offset %0d: got %b, want %b",
                                              oldest.offset, is_header, oldest.hdr));
                end
                if (last !== oldest.is_last)
                begin
                    report_mismatch($sformatf("last at offset %0d: got %b, want %b",
                                              oldest.offset, last, oldest.is_last));
                end
                if (too_long !== oldest.ovf)
                begin
                    report_mismatch($sformatf("too_long at offset %0d: got %b, want %b",
                                              oldest.offset, too_long, oldest.ovf));
                end
            end
        end
    end

    // ends the run once nothing has moved on either side for too long
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("ipv4_tcp_udp_header_builder regression: fail");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gap_pct   = 20;
        recv_stall_pct = 20;
        test_before_descriptor();
        test_field_extremes();
        test_udp_zero_checksum();
        test_close_repeat();
        test_remap();
        test_payload_limit();
        test_random_traffic();
        wait_for_results();
        if (mismatch_count == 0)
        begin
            $display("ipv4_tcp_udp_header_builder regression: pass");
        end
        else
        begin
            $display("ipv4_tcp_udp_header_builder regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ihb_pkg.sv
rtl/ihb_front.sv
rtl/ihb_queue.sv
rtl/ihb_back.sv
rtl/ipv4_tcp_udp_header_builder.sv
rtl/ihb_checker.sv
test/tb.sv
